/* sv/hrlp_pkg.sv */
// Package for the HTTP request-line parser: word types, parse mode codes,
// method name table and hex digit decode. No dependencies.
package hrlp_pkg;

   typedef struct packed {
      logic [7:0] req_byte;
      logic       last_byte;
   } req_word_type;

   typedef struct packed {
      logic        out_kind;
      logic [7:0]  path_char;
      logic [3:0]  method_code;
      logic        path_ok;
      logic [12:0] path_length;
      logic        run_end;
   } rsp_word_type;

   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_ESCAPE = 2'd1;
   localparam logic [1:0] MODE_DONE   = 2'd2;

   localparam logic KIND_PATH    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam int          NUM_METHODS    = 9;
   localparam logic [3:0]  METHOD_UNKNOWN = 4'd9;
   localparam logic [8:0]  ALL_METHODS    = 9'h1FF;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;

   localparam int QUEUE_DEPTH = 8;

   localparam logic [7:0] METHOD_NAMES [NUM_METHODS][8] = '{
      '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"P", "O", "S", "T",   8'h00, 8'h00, 8'h00, 8'h00},
      '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"D", "E", "L", "E",   "T",   "E",   8'h00, 8'h00},
      '{"H", "E", "A", "D",   8'h00, 8'h00, 8'h00, 8'h00},
      '{"C", "O", "N", "N",   "E",   "C",   "T",   8'h00},
      '{"O", "P", "T", "I",   "O",   "N",   "S",   8'h00},
      '{"T", "R", "A", "C",   "E",   8'h00, 8'h00, 8'h00},
      '{"P", "A", "T", "C",   "H",   8'h00, 8'h00, 8'h00}
   };

   localparam logic [3:0] METHOD_LENS [NUM_METHODS] = '{
      4'd3, 4'd4, 4'd3, 4'd6, 4'd4, 4'd7, 4'd7, 4'd5, 4'd5
   };

   // 0-9, A-F, a-f give their value; anything else decodes as zero
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c >= "0" && c <= "9") begin
         v = c - 8'h30;
      end else if (c >= "A" && c <= "F") begin
         v = c - 8'h37;
      end else if (c >= "a" && c <= "f") begin
         v = c - 8'h57;
      end
      return v[3:0];
   endfunction

endpackage

/* sv/http_request_line_parser.sv */
// A byte's first result word passes the input register and the result queue before it is offered.
// Throughput: one byte per cycle while req_stall is low; a byte that yields a path byte and a summary
// gives two result words, absorbed by an eight-word result queue (input stalls
// once more than four words are queued).
// Reset: synchronous, active high; parser state and the result queue are cleared.
// Uses hrlp_pkg for word types, mode codes, method table and hex decode.
module http_request_line_parser #(
   parameter int MAX_LINE = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  hrlp_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output hrlp_pkg::rsp_word_type rsp_data
);
   import hrlp_pkg::*;

   localparam int PtrW = $clog2(QUEUE_DEPTH);
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [12:0] LenCap = 13'((MAX_LINE < 8191) ? MAX_LINE : 8191);
   localparam logic [CntW-1:0] StallLevel = CntW'(QUEUE_DEPTH - 4);

   // input register
   logic         in_valid_ff;
   req_word_type in_word_ff;

   // parser state
   logic [1:0]  mode_ff, mode_in;
   logic        esc_high_pending_ff, esc_high_pending_in;
   logic [3:0]  esc_nibble_ff, esc_nibble_in;
   logic [1:0]  token_idx_ff, token_idx_in;
   logic        token_nonempty_ff, token_nonempty_in;
   logic [8:0]  match_ff, match_in;
   logic [3:0]  char_pos_ff, char_pos_in;
   logic [12:0] path_count_ff, path_count_in;

   // result queue
   rsp_word_type        queue_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]     count_ff;

   rsp_word_type word0, word1;
   logic [1:0]   n_words;
   logic         pop;

   assign req_stall = count_ff > StallLevel;
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = queue_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= req_valid && !req_stall;
      end
      if (req_valid && !req_stall) begin
         in_word_ff <= req_data;
      end
   end

   always_comb begin
      logic [7:0] c;
      logic       have_byte;
      logic [7:0] dec;
      logic       have_path;
      logic       have_summary;
      logic [7:0] pchar;
      logic       ok;
      logic [3:0] meth;
      rsp_word_type summ;

      c            = in_word_ff.req_byte;
      have_byte    = 1'b0;
      dec          = c;
      have_path    = 1'b0;
      have_summary = 1'b0;
      pchar        = 8'h00;
      ok           = 1'b0;
      meth         = METHOD_UNKNOWN;

      mode_in             = mode_ff;
      esc_high_pending_in = esc_high_pending_ff;
      esc_nibble_in       = esc_nibble_ff;
      token_idx_in        = token_idx_ff;
      token_nonempty_in   = token_nonempty_ff;
      match_in            = match_ff;
      char_pos_in         = char_pos_ff;
      path_count_in       = path_count_ff;

      if (in_valid_ff) begin
         unique case (mode_ff)
            MODE_ESCAPE: begin
               if (esc_high_pending_ff) begin
                  esc_nibble_in       = hex_value(c);
                  esc_high_pending_in = 1'b0;
               end else begin
                  mode_in   = MODE_NORMAL;
                  dec       = {esc_nibble_ff, hex_value(c)};
                  have_byte = 1'b1;
               end
            end
            MODE_NORMAL: begin
               priority if (c == CHAR_NEWLINE || c == CHAR_SPACE) begin
                  // token end: a newline only counts a non-empty token
                  if (c == CHAR_SPACE || token_nonempty_ff) begin
                     if (token_idx_ff == 2'd0) begin
                        for (int i = 0; i < NUM_METHODS; i++) begin
                           if (METHOD_LENS[i] != char_pos_ff) begin
                              match_in[i] = 1'b0;
                           end
                        end
                     end
                     if (token_idx_ff < 2'd2) begin
                        token_idx_in = token_idx_ff + 2'd1;
                     end
                     token_nonempty_in = 1'b0;
                  end
                  if (c == CHAR_NEWLINE) begin
                     mode_in      = MODE_DONE;
                     have_summary = 1'b1;
                  end
               end else if (c == CHAR_PERCENT) begin
                  mode_in             = MODE_ESCAPE;
                  esc_high_pending_in = 1'b1;
                  esc_nibble_in       = 4'd0;
               end else begin
                  have_byte = 1'b1;
               end
            end
            default: begin
               // done: bytes are dropped until the last byte
            end
         endcase

         if (have_byte) begin
            token_nonempty_in = 1'b1;
            if (token_idx_ff == 2'd0) begin
               for (int i = 0; i < NUM_METHODS; i++) begin
                  if (char_pos_ff >= METHOD_LENS[i] ||
                      METHOD_NAMES[i][char_pos_ff[2:0]] != dec) begin
                     match_in[i] = 1'b0;
                  end
               end
               if (char_pos_ff < 4'd15) begin
                  char_pos_in = char_pos_ff + 4'd1;
               end
            end else if (token_idx_ff == 2'd1) begin
               if (path_count_ff < LenCap) begin
                  path_count_in = path_count_ff + 13'd1;
               end
               have_path = 1'b1;
               pchar     = dec;
            end
         end

         if (in_word_ff.last_byte && mode_in != MODE_DONE) begin
            have_summary = 1'b1;
         end
      end

      ok = token_idx_in >= 2'd2;
      if (ok) begin
         for (int i = NUM_METHODS - 1; i >= 0; i--) begin
            if (match_in[i]) begin
               meth = 4'(i);
            end
         end
      end

      summ.out_kind    = KIND_SUMMARY;
      summ.path_char   = 8'h00;
      summ.method_code = meth;
      summ.path_ok     = ok;
      summ.path_length = path_count_in;
      summ.run_end     = 1'b1;

      word0.out_kind    = KIND_PATH;
      word0.path_char   = pchar;
      word0.method_code = 4'd0;
      word0.path_ok     = 1'b0;
      word0.path_length = 13'd0;
      word0.run_end     = !have_summary;
      word1             = summ;

      if (have_path && have_summary) begin
         n_words = 2'd2;
      end else if (have_path) begin
         n_words = 2'd1;
      end else if (have_summary) begin
         n_words = 2'd1;
         word0   = summ;
      end else begin
         n_words = 2'd0;
      end

      // last byte: back to the reset state for the next request
      if (in_valid_ff && in_word_ff.last_byte) begin
         mode_in             = MODE_NORMAL;
         esc_high_pending_in = 1'b0;
         esc_nibble_in       = 4'd0;
         token_idx_in        = 2'd0;
         token_nonempty_in   = 1'b0;
         match_in            = ALL_METHODS;
         char_pos_in         = 4'd0;
         path_count_in       = 13'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff             <= MODE_NORMAL;
         esc_high_pending_ff <= 1'b0;
         esc_nibble_ff       <= 4'd0;
         token_idx_ff        <= 2'd0;
         token_nonempty_ff   <= 1'b0;
         match_ff            <= ALL_METHODS;
         char_pos_ff         <= 4'd0;
         path_count_ff       <= 13'd0;
         wr_ptr_ff           <= '0;
         rd_ptr_ff           <= '0;
         count_ff            <= '0;
      end else begin
         mode_ff             <= mode_in;
         esc_high_pending_ff <= esc_high_pending_in;
         esc_nibble_ff       <= esc_nibble_in;
         token_idx_ff        <= token_idx_in;
         token_nonempty_ff   <= token_nonempty_in;
         match_ff            <= match_in;
         char_pos_ff         <= char_pos_in;
         path_count_ff       <= path_count_in;
         wr_ptr_ff           <= wr_ptr_ff + PtrW'(n_words);
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PtrW'(1);
         end
         count_ff <= count_ff + CntW'(n_words) - CntW'(pop);
      end
      if (n_words != 2'd0) begin
         queue_ff[wr_ptr_ff] <= word0;
      end
      if (n_words == 2'd2) begin
         queue_ff[wr_ptr_ff + PtrW'(1)] <= word1;
      end
   end

endmodule

/* tb/tb_http_request_line_parser.sv */
// Self-checking testbench for http_request_line_parser: request bytes in, path bytes
// and end-of-line summaries out, checked against a request-line parse model.
// Depends on hrlp_pkg for the word types and the character and mode codes.
`timescale 1ns / 1ps

module tb_http_request_line_parser;
   import hrlp_pkg::*;

   localparam int MAX_LINE = 4096;
   localparam int LEN_CAP = (MAX_LINE < 8191) ? MAX_LINE : 8191;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int MAX_REPORTS = 10;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;

   http_request_line_parser #(
      .MAX_LINE(MAX_LINE)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // parse model state
   logic [1:0]  line_mode;
   logic        esc_high_pending;
   logic [3:0]  esc_nibble;
   logic [1:0]  tok_count;
   logic        tok_has_bytes;
   logic [8:0]  method_live;
   logic [3:0]  method_pos;
   logic [12:0] path_len;

   string method_names [NUM_METHODS] = '{
      "GET", "POST", "PUT", "DELETE", "HEAD", "CONNECT", "OPTIONS", "TRACE", "PATCH"
   };
   string hex_chars = "0123456789abcdefABCDEF";

   rsp_word_type expected_words [$];
   rsp_word_type step_words [$];
   logic [7:0]   line_buf [$];

   int  fail_count = 0;
   int  cycle_count = 0;
   int  parsed_bytes = 0;
   bit  req_idle_on = 1'b0;
   bit  rsp_idle_on = 1'b0;

   function automatic logic [3:0] digit_value(input logic [7:0] c);
      logic [7:0] v;
      v = 8'd0;
      if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
      else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h41 + 8'd10;
      else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h61 + 8'd10;
      return v[3:0];
   endfunction

   task automatic add_byte(input logic [7:0] b);
      line_buf.insert(line_buf.size(), b);
   endtask

   task automatic clear_line();
      line_mode = MODE_NORMAL;
      esc_high_pending = 1'b0;
      esc_nibble = 4'd0;
      tok_count = 2'd0;
      tok_has_bytes = 1'b0;
      method_live = 9'h1FF;
      method_pos = 4'd0;
      path_len = 13'd0;
   endtask

   task automatic take_char(input logic [7:0] c);
      rsp_word_type w;
      int i;
      tok_has_bytes = 1'b1;
      if (tok_count == 2'd0) begin
         for (i = 0; i < NUM_METHODS; i++) begin
            if (method_pos >= method_names[i].len() || method_names[i][method_pos] != c)
               method_live[i] = 1'b0;
         end
         if (method_pos < 4'd15) method_pos = method_pos + 4'd1;
      end else if (tok_count == 2'd1) begin
         if (path_len < LEN_CAP) path_len = path_len + 13'd1;
         w = '0;
         w.out_kind = KIND_PATH;
         w.path_char = c;
         step_words.insert(step_words.size(), w);
      end
   endtask

   task automatic close_token();
      int i;
      if (tok_count == 2'd0) begin
         for (i = 0; i < NUM_METHODS; i++) begin
            if (method_names[i].len() != method_pos) method_live[i] = 1'b0;
         end
      end
      if (tok_count < 2'd2) tok_count = tok_count + 2'd1;
      tok_has_bytes = 1'b0;
   endtask

   task automatic push_summary();
      rsp_word_type w;
      int i;
      w = '0;
      w.out_kind = KIND_SUMMARY;
      w.path_ok = (tok_count >= 2'd2);
      w.method_code = METHOD_UNKNOWN;
      if (w.path_ok) begin
         for (i = NUM_METHODS - 1; i >= 0; i--) begin
            if (method_live[i]) w.method_code = 4'(i);
         end
      end
      w.path_length = path_len;
      step_words.insert(step_words.size(), w);
   endtask

   // work out the words one accepted byte causes and queue them
   task automatic parse_byte(input logic [7:0] c, input logic last);
      rsp_word_type w;
      int i;
      step_words.delete();
      if (line_mode == MODE_ESCAPE) begin
         if (esc_high_pending) begin
            esc_nibble = digit_value(c);
            esc_high_pending = 1'b0;
         end else begin
            line_mode = MODE_NORMAL;
            take_char({esc_nibble, digit_value(c)});
         end
      end else if (line_mode == MODE_NORMAL) begin
         if (c == CHAR_NEWLINE) begin
            if (tok_has_bytes) close_token();
            line_mode = MODE_DONE;
            push_summary();
         end else if (c == CHAR_SPACE) begin
            close_token();
         end else if (c == CHAR_PERCENT) begin
            line_mode = MODE_ESCAPE;
            esc_high_pending = 1'b1;
            esc_nibble = 4'd0;
         end else begin
            take_char(c);
         end
      end
      if (last) begin
         if (line_mode != MODE_DONE) push_summary();
         clear_line();
      end
      if (step_words.size() > 0) begin
         w = step_words.pop_back();
         w.run_end = 1'b1;
         step_words.insert(step_words.size(), w);
      end
      for (i = 0; i < step_words.size(); i++)
         expected_words.insert(expected_words.size(), step_words[i]);
   endtask

   // stall is sampled at the falling edge, where it holds the value seen at the next rise
   task automatic send_byte(input logic [7:0] c, input logic last);
      int gap;
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 18);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{req_byte: c, last_byte: last};
      @(negedge clock);
      while (req_stall !== 1'b0) @(negedge clock);
      @(posedge clock);
      if (line_mode != MODE_DONE) parsed_bytes++;
      parse_byte(c, last);
   endtask

   task automatic send_line();
      int i;
      for (i = 0; i < line_buf.size(); i++) send_byte(line_buf[i], i == line_buf.size() - 1);
      line_buf.delete();
   endtask

   task automatic push_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   function automatic logic [7:0] plain_byte();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(0, 255));
      end while (c == CHAR_SPACE || c == CHAR_NEWLINE || c == CHAR_PERCENT);
      return c;
   endfunction

   function automatic logic [7:0] escape_digit();
      if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
      return hex_chars[$urandom_range(0, hex_chars.len() - 1)];
   endfunction

   task automatic push_escape();
      add_byte(CHAR_PERCENT);
      add_byte(escape_digit());
      add_byte(escape_digit());
   endtask

   // mostly well-formed request lines with random method, path and tail
   task automatic build_request();
      int k;
      int n;
      int idx;
      line_buf.delete();
      k = $urandom_range(0, NUM_METHODS - 1);
      case ($urandom_range(0, 19))
         0, 1, 2: begin
            push_text(method_names[k]);
            idx = $urandom_range(0, line_buf.size() - 1);
            case ($urandom_range(0, 2))
               0: line_buf[idx] = line_buf[idx] ^ 8'h20;
               1: add_byte(8'h53);
               default: void'(line_buf.pop_back());
            endcase
         end
         3, 4: begin
            n = $urandom_range(0, 9);
            repeat (n) add_byte(plain_byte());
         end
         default: push_text(method_names[k]);
      endcase
      add_byte(CHAR_SPACE);
      if ($urandom_range(0, 15) == 0) add_byte(CHAR_SPACE);
      n = $urandom_range(0, 14);
      repeat (n) begin
         if ($urandom_range(0, 4) == 0) push_escape();
         else add_byte(plain_byte());
      end
      if ($urandom_range(0, 2) != 0) push_text(" HTTP/1.1");
      else if ($urandom_range(0, 5) == 0) add_byte(CHAR_PERCENT);
      if ($urandom_range(0, 9) != 0) begin
         add_byte(CHAR_NEWLINE);
         n = $urandom_range(0, 3);
         repeat (n) add_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_edge_requests();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      // upper and lower hex escapes, then a byte after the newline carrying last
      push_text("GET /%4a%fF");
      add_byte(CHAR_NEWLINE);
      add_byte(8'h78);
      send_line();
      // empty method, escape digits that are percent and newline, open path at last
      add_byte(CHAR_SPACE);
      add_byte(CHAR_PERCENT);
      add_byte(CHAR_PERCENT);
      add_byte(CHAR_NEWLINE);
      add_byte(8'hFF);
      send_line();
      // newline as the only byte
      add_byte(CHAR_NEWLINE);
      send_line();
      // zero byte as the only byte
      add_byte(8'h00);
      send_line();
      // last byte lands inside an escape
      push_text("a b%4");
      send_line();
   endtask

   task automatic test_long_path();
      int i;
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      push_text("PUT /");
      for (i = 0; i < 300; i++) begin
         if (i % 64 == 0) push_escape();
         else add_byte(plain_byte());
      end
      push_text(" HTTP/1.1");
      add_byte(CHAR_NEWLINE);
      send_line();
   endtask

   task automatic test_random_requests();
      int start;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      start = parsed_bytes;
      while (parsed_bytes - start < 650) begin
         build_request();
         send_line();
      end
   endtask

   task automatic test_byte_noise();
      logic [7:0] c;
      repeat (250) begin
         case ($urandom_range(0, 11))
            0: c = CHAR_SPACE;
            1: c = CHAR_NEWLINE;
            2: c = CHAR_PERCENT;
            default: c = 8'($urandom_range(0, 255));
         endcase
         send_byte(c, $urandom_range(0, 11) == 0);
      end
      send_byte(CHAR_NEWLINE, 1'b1);
   endtask

   task automatic test_back_to_back();
      int start;
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      start = parsed_bytes;
      while (parsed_bytes - start < 150) begin
         build_request();
         send_line();
      end
   endtask

   initial begin : rsp_backpressure
      int burst;
      burst = 0;
      forever begin
         @(posedge clock);
         if (burst == 0 && rsp_idle_on && $urandom_range(0, 7) == 0)
            burst = $urandom_range(1, 18);
         if (burst > 0) begin
            rsp_stall <= 1'b1;
            burst--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : check_words
      rsp_word_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_words.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("unexpected word: kind=%0d char=%02h method=%0d ok=%0d len=%0d end=%0d",
                        rsp_data.out_kind, rsp_data.path_char, rsp_data.method_code,
                        rsp_data.path_ok, rsp_data.path_length, rsp_data.run_end);
         end else begin
            want = expected_words.pop_front();
            if (rsp_data.out_kind !== want.out_kind || rsp_data.path_char !== want.path_char ||
                rsp_data.method_code !== want.method_code ||
                rsp_data.path_ok !== want.path_ok ||
                rsp_data.path_length !== want.path_length ||
                rsp_data.run_end !== want.run_end) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS) begin
                  $display("mismatch: expected kind=%0d char=%02h method=%0d ok=%0d len=%0d end=%0d",
                           want.out_kind, want.path_char, want.method_code, want.path_ok,
                           want.path_length, want.run_end);
                  $display("          got      kind=%0d char=%02h method=%0d ok=%0d len=%0d end=%0d",
                           rsp_data.out_kind, rsp_data.path_char, rsp_data.method_code,
                           rsp_data.path_ok, rsp_data.path_length, rsp_data.run_end);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("http_request_line_parser regression: fail");
         $finish;
      end
   end

   initial begin
      clear_line();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_edge_requests();
      test_long_path();
      test_random_requests();
      test_byte_noise();
      test_back_to_back();
      req_valid <= 1'b0;
      while (expected_words.size() > 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (fail_count == 0) begin
         $display("http_request_line_parser regression: pass");
      end else begin
         $display("http_request_line_parser regression: fail");
      end
      $finish;
   end

endmodule
